// ----- rtl/core/differential_drive_odometry_macros.svh -----
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// property must hold at every edge out of reset
`define DOD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define DOD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/core/dod_pkg.sv -----
// ----------------------------------------------------------------------------
// dod_pkg
// Types, constants and helpers shared by the odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package dod_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicIters = (CordicSteps > 30) ? 30 : CordicSteps;
  localparam int CordicCntW  = $clog2(CordicIters);
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam int MulAW   = 64;
  localparam int MulBW   = 34;
  localparam int MulPW   = MulAW + MulBW + 1;
  localparam int MulCntW = $clog2(MulBW);

  localparam int RegAddrW = 4;

  typedef enum logic [1:0] {
    REG_LEFT_DPT  = 2'd0,
    REG_RIGHT_DPT = 2'd1,
    REG_ANGLE_PM  = 2'd2,
    REG_TPS       = 2'd3
  } dod_reg_e;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] count_left;
    logic signed [31:0] count_right;
  } dod_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] speed_left;
    logic signed [31:0] speed_right;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
  } dod_out_t;

  typedef struct packed {
    logic [23:0] left_dpt;
    logic [23:0] right_dpt;
    logic [31:0] angle_pm;
    logic [15:0] tps;
  } dod_cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } dod_mul_req_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [MulPW-1:0] v);
    logic signed [31:0] r;
    if ((&v[MulPW-1:31]) || !(|v[MulPW-1:31])) begin
      r = v[31:0];
    end else if (v[MulPW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose tracker for a two-wheel base, built around a shared
// bit-serial multiplier and an iterative CORDIC.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   --------  ---------  -------------------------  -----------------------
//   in        sink       in_valid_i / in_stall_o    dod_in_t  (kind, counts)
//   out       source     out_valid_o / out_stall_i  dod_out_t (pose, rates)
//   config    APB        psel/penable/pwrite        4 x 32-bit registers
//
// A re-zero request goes from accept straight to the finish step, which loads
// the result. A sample tick runs ten products on the shared serial
// multiplier (34 multiplier bits each, plus launch and capture) and the
// CORDIC rotations, one after another, before the finish step.
// One request is in flight at a time; in_stall_o is high while it is worked.
// The result sits in an output register, so the next request is taken while
// the previous result is still stalled. Reset clears pose, counts and offset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "differential_drive_odometry_macros.svh"

module differential_drive_odometry import dod_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dod_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dod_out_t            out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WL, ST_WR, ST_SUM, ST_SPL, ST_SPR, ST_ROT,
    ST_DX, ST_DY, ST_DTH, ST_VX, ST_VY, ST_TURN, ST_FIN
  } state_e;

  // rounds a negative product toward zero before the 2^-48 scale
  localparam logic [MulPW-1:0] DthRound = (MulPW'(1) << 48) - MulPW'(1);

  state_e   state_q;
  logic     wait_q;
  dod_in_t  in_q;
  dod_cfg_t cfg;

  logic        [31:0] last_left_q, last_right_q;
  logic        [31:0] x_acc_q, y_acc_q, angle_acc_q;
  logic signed [31:0] bias_vx_q, bias_vy_q;
  logic               bias_taken_q;

  // per-tick intermediates
  logic signed [56:0] wl_q, wr_q;
  logic signed [31:0] ds_q, spl_q, spr_q, turn_q;
  logic signed [57:0] diff_q;
  logic signed [33:0] cos_q, sin_q;
  logic signed [35:0] dx_q, dy_q;
  logic signed [40:0] dth_q;
  logic signed [52:0] vx_q, vy_q;

  dod_out_t out_q;
  logic     out_valid_q;

  dod_mul_req_t            mul_req;
  logic                    mul_done, rot_done;
  logic signed [MulPW-1:0] prod;
  logic signed [33:0]      rot_cos, rot_sin;

  logic signed [31:0] dl, dr;
  logic signed [57:0] wsum;
  logic [MulPW-1:0]   dth_rnd;
  logic               is_mul, out_adv, in_acc;
  logic signed [31:0] vx_sat, vy_sat, bias_x_use, bias_y_use;

  dod_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  dod_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .done_o(mul_done), .prod_o(prod)
  );

  dod_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i(state_q == ST_ROT && !wait_q),
    .angle_i(angle_acc_q),
    .done_o (rot_done),
    .cos_o  (rot_cos),
    .sin_o  (rot_sin)
  );

  // wrapped count deltas
  assign dl = $signed(in_q.count_left  - last_left_q);
  assign dr = $signed(in_q.count_right - last_right_q);

  assign wsum    = 58'(wl_q) + 58'(wr_q);
  assign dth_rnd = prod + (prod[MulPW-1] ? DthRound : '0);

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_adv = !out_valid_q || !out_stall_i;

  // first tick after re-zero captures the velocity offset
  assign vx_sat     = sat32(MulPW'(vx_q));
  assign vy_sat     = sat32(MulPW'(vy_q));
  assign bias_x_use = bias_taken_q ? bias_vx_q : vx_sat;
  assign bias_y_use = bias_taken_q ? bias_vy_q : vy_sat;

  // operand select for the shared multiplier
  always_comb begin
    is_mul    = 1'b1;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state_q)
      ST_WL:   begin mul_req.a = MulAW'(dl); mul_req.b = MulBW'(cfg.left_dpt);  end
      ST_WR:   begin mul_req.a = MulAW'(dr); mul_req.b = MulBW'(cfg.right_dpt); end
      ST_SPL:  begin mul_req.a = MulAW'(wl_q >>> 12); mul_req.b = MulBW'(cfg.tps); end
      ST_SPR:  begin mul_req.a = MulAW'(wr_q >>> 12); mul_req.b = MulBW'(cfg.tps); end
      ST_DX:   begin mul_req.a = MulAW'(ds_q); mul_req.b = cos_q; end
      ST_DY:   begin mul_req.a = MulAW'(ds_q); mul_req.b = sin_q; end
      ST_DTH:  begin mul_req.a = MulAW'(diff_q); mul_req.b = MulBW'(cfg.angle_pm); end
      ST_VX:   begin mul_req.a = MulAW'(dx_q); mul_req.b = MulBW'(cfg.tps); end
      ST_VY:   begin mul_req.a = MulAW'(dy_q); mul_req.b = MulBW'(cfg.tps); end
      ST_TURN: begin mul_req.a = MulAW'(dth_q); mul_req.b = MulBW'(cfg.tps); end
      default: is_mul = 1'b0;
    endcase
    mul_req.start = is_mul && !wait_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wait_q       <= 1'b0;
      in_q         <= '0;
      last_left_q  <= '0;
      last_right_q <= '0;
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      angle_acc_q  <= '0;
      bias_vx_q    <= '0;
      bias_vy_q    <= '0;
      bias_taken_q <= 1'b0;
      wl_q         <= '0;
      wr_q         <= '0;
      ds_q         <= '0;
      diff_q       <= '0;
      spl_q        <= '0;
      spr_q        <= '0;
      cos_q        <= '0;
      sin_q        <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      dth_q        <= '0;
      vx_q         <= '0;
      vy_q         <= '0;
      turn_q       <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            in_q    <= in_data_i;
            state_q <= in_data_i.kind ? ST_FIN : ST_WL;
          end
        end
        ST_SUM: begin
          ds_q    <= sat32(MulPW'(wsum >>> 13));
          diff_q  <= 58'(wr_q) - 58'(wl_q);
          state_q <= ST_SPL;
        end
        ST_ROT: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (rot_done) begin
            cos_q   <= rot_cos;
            sin_q   <= rot_sin;
            wait_q  <= 1'b0;
            state_q <= ST_DX;
          end
        end
        ST_FIN: begin
          if (out_adv) begin
            out_valid_q  <= 1'b1;
            last_left_q  <= in_q.count_left;
            last_right_q <= in_q.count_right;
            state_q      <= ST_IDLE;
            if (in_q.kind) begin
              // re-zero: pose cleared, offsets kept but re-armed
              x_acc_q      <= '0;
              y_acc_q      <= '0;
              angle_acc_q  <= '0;
              bias_taken_q <= 1'b0;
              out_q        <= '0;
            end else begin
              x_acc_q      <= x_acc_q + dx_q[31:0];
              y_acc_q      <= y_acc_q + dy_q[31:0];
              angle_acc_q  <= angle_acc_q + dth_q[31:0];
              bias_vx_q    <= bias_x_use;
              bias_vy_q    <= bias_y_use;
              bias_taken_q <= 1'b1;
              out_q.pos_x       <= $signed(x_acc_q + dx_q[31:0]);
              out_q.pos_y       <= $signed(y_acc_q + dy_q[31:0]);
              out_q.heading     <= angle_acc_q + dth_q[31:0];
              out_q.speed_left  <= spl_q;
              out_q.speed_right <= spr_q;
              out_q.vel_x       <= sat32(MulPW'(54'(vx_q) - 54'(bias_x_use)));
              out_q.vel_y       <= sat32(MulPW'(54'(vy_q) - 54'(bias_y_use)));
              out_q.turn_rate   <= turn_q;
            end
          end
        end
        default: begin
          // multiplier steps: launch, then wait for the product
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (mul_done) begin
            wait_q <= 1'b0;
            unique case (state_q)
              ST_WL:   begin wl_q <= prod[56:0]; state_q <= ST_WR; end
              ST_WR:   begin wr_q <= prod[56:0]; state_q <= ST_SUM; end
              ST_SPL:  begin spl_q <= sat32(prod); state_q <= ST_SPR; end
              ST_SPR:  begin spr_q <= sat32(prod); state_q <= ST_ROT; end
              ST_DX:   begin dx_q <= prod[65:30]; state_q <= ST_DY; end
              ST_DY:   begin dy_q <= prod[65:30]; state_q <= ST_DTH; end
              ST_DTH:  begin dth_q <= dth_rnd[88:48]; state_q <= ST_VX; end
              ST_VX:   begin vx_q <= prod[52:0]; state_q <= ST_VY; end
              ST_VY:   begin vy_q <= prod[52:0]; state_q <= ST_TURN; end
              ST_TURN: begin turn_q <= sat32(prod); state_q <= ST_FIN; end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DOD_ASSERT(a_accept_leaves_idle, in_acc |=> (state_q != ST_IDLE), "request accepted but sequencer stayed idle")
  `DOD_ASSERT_NEVER(a_units_exclusive, mul_done && rot_done, "multiplier and CORDIC finished together")
  `DOD_ASSERT(a_fin_loads_result, (state_q == ST_FIN && out_adv) |=> out_valid_q, "finished request did not reach the output register")

endmodule

`default_nettype wire

// ----- rtl/core/dod_mul.sv -----
// ----------------------------------------------------------------------------
// dod_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, radix 2.
// ----------------------------------------------------------------------------
`default_nettype none

module dod_mul import dod_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dod_mul_req_t            req_i,
  output logic                    done_o,
  output logic signed [MulPW-1:0] prod_o
);

  logic                    busy_q, done_q;
  logic [MulCntW-1:0]      cnt_q;
  logic signed [MulAW:0]   acc_q;
  logic [MulBW-1:0]        mq_q;
  logic signed [MulAW-1:0] a_q;
  logic signed [MulAW+1:0] addend, sum;
  logic                    last;

  assign last = (cnt_q == MulCntW'(MulBW - 1));

  // sign bit of the multiplier weighs negative
  always_comb begin
    addend = '0;
    if (mq_q[0]) begin
      addend = last ? -((MulAW+2)'(a_q)) : (MulAW+2)'(a_q);
    end
    sum = (MulAW+2)'(acc_q) + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      mq_q  <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum[MulAW+1:1];
      mq_q  <= {sum[0], mq_q[MulBW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed({acc_q, mq_q});

endmodule

`default_nettype wire

// ----- rtl/core/dod_cordic.sv -----
// ----------------------------------------------------------------------------
// dod_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dod_cordic import dod_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic                  busy_q, done_q, flip_q;
  logic [CordicCntW-1:0] cnt_q;
  logic signed [33:0]    x_q, y_q, tx, ty;
  logic signed [32:0]    z_q, at;
  logic [31:0]           shifted, ang_f;
  logic                  last;

  // fold into [-90, 90) degrees
  assign shifted = angle_i + 32'h4000_0000;
  assign ang_f   = shifted[31] ? (angle_i + 32'h8000_0000) : angle_i;
  assign last    = (cnt_q == CordicCntW'(CordicIters - 1));

  always_comb begin
    tx = y_q >>> cnt_q;
    ty = x_q >>> cnt_q;
    at = $signed({1'b0, atan_entry(5'(cnt_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= 33'($signed(ang_f));
      flip_q <= shifted[31];
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - tx;
        y_q <= y_q + ty;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + tx;
        y_q <= y_q - ty;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

// ----- rtl/core/dod_cfg.sv -----
// ----------------------------------------------------------------------------
// dod_cfg
// APB register file for the odometry settings.
// ----------------------------------------------------------------------------
`default_nettype none

module dod_cfg import dod_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dod_cfg_t            cfg_o
);

  dod_cfg_t cfg_q;
  dod_reg_e idx;
  logic     wr_en;

  assign idx    = dod_reg_e'(paddr[RegAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_dpt  <= '0;
      cfg_q.right_dpt <= '0;
      cfg_q.angle_pm  <= '0;
      cfg_q.tps       <= 16'd10;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT_DPT:  cfg_q.left_dpt  <= pwdata[23:0];
        REG_RIGHT_DPT: cfg_q.right_dpt <= pwdata[23:0];
        REG_ANGLE_PM:  cfg_q.angle_pm  <= pwdata;
        REG_TPS:       cfg_q.tps       <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT_DPT:  prdata = {8'd0, cfg_q.left_dpt};
      REG_RIGHT_DPT: prdata = {8'd0, cfg_q.right_dpt};
      REG_ANGLE_PM:  prdata = cfg_q.angle_pm;
      REG_TPS:       prdata = {16'd0, cfg_q.tps};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- tb/tb_differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Self-checking bench for the odometry core. A queue-fed driver offers
// encoder requests and a monitor predicts each pose result, then checks it
// field by field. Register settings are changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_differential_drive_odometry;
  import dod_pkg::*;

  localparam int HoldCycles = 900;    // long receiver hold-off
  localparam int IdleLimit  = 20000;  // cycles with no handshake while busy
  localparam int Settle     = 400;    // final wait before the last check

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  dod_in_t in_data_i;
  dod_out_t out_data_o;
  logic psel, penable, pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  differential_drive_odometry i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // requests waiting to be offered, and pose results still owed
  dod_in_t  pending_reqs[$];
  dod_out_t pose_expected[$];

  // bench copy of the register file
  logic [23:0] m_left_dpt, m_right_dpt;
  logic [31:0] m_angle_pm;
  logic [15:0] m_tps;

  // bench copy of the tracker state
  logic [31:0] m_last_l, m_last_r, m_x, m_y, m_ang;
  longint      m_bias_vx, m_bias_vy;
  bit          m_bias_taken;

  int  n_errors, n_reqs, n_results, n_rezero;
  bit  jitter_on;
  int  hold_reqs, hold_seen, hold_left;
  bit  req_taken;
  int  idle_cnt;

  // arctangent steps in binary-angle units
  localparam longint AtanSteps[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint as_signed(logic [31:0] u);
    return longint'(signed'(u));
  endfunction

  // cos/sin of a binary angle, Q30, folded into the right half-plane
  task automatic rotate_unit(input logic [31:0] ang, output longint c,
                             output longint s);
    longint x, y, z, tx, ty;
    logic [31:0] a, probe;
    bit flip;
    x = 652032874;
    y = 0;
    a = ang;
    probe = a + 32'h4000_0000;
    flip = (probe >= 32'h8000_0000);
    if (flip) a = a + 32'h8000_0000;
    z = as_signed(a);
    for (int i = 0; i < CordicIters; i++) begin
      tx = y >>> i;
      ty = x >>> i;
      if (z >= 0) begin
        x -= tx; y += ty; z -= AtanSteps[i];
      end else begin
        x += tx; y -= ty; z += AtanSteps[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // advance the tracker by one request and return the pose it reports
  task automatic track_pose(input dod_in_t req, output dod_out_t pose);
    longint tps, wl, wr, ds, c, s, dx, dy, diff, mag, a, b, q, dth, vx, vy;
    pose = '0;
    if (req.kind) begin
      m_last_l = req.count_left;
      m_last_r = req.count_right;
      m_x = '0; m_y = '0; m_ang = '0;
      m_bias_taken = 1'b0;
      return;
    end
    tps = longint'(m_tps);
    wl = as_signed(req.count_left - m_last_l) * longint'(m_left_dpt);
    wr = as_signed(req.count_right - m_last_r) * longint'(m_right_dpt);
    m_last_l = req.count_left;
    m_last_r = req.count_right;
    pose.speed_left  = 32'(clamp32((wl >>> 12) * tps));
    pose.speed_right = 32'(clamp32((wr >>> 12) * tps));
    ds = clamp32((wl + wr) >>> 13);
    rotate_unit(m_ang, c, s);      // heading before this tick
    dx = (ds * c) >>> 30;
    dy = (ds * s) >>> 30;
    m_x += dx[31:0];
    m_y += dy[31:0];
    // wheel difference times Q16.16 gain over 2^48, split to stay in 64 bits
    diff = wr - wl;
    mag = (diff < 0) ? -diff : diff;
    a = (mag >> 28) * longint'(m_angle_pm);
    b = (mag & 64'hFFF_FFFF) * longint'(m_angle_pm);
    q = (a >> 20) + ((((a & 64'hF_FFFF) << 28) + b) >> 48);
    dth = (diff < 0) ? -q : q;
    m_ang += dth[31:0];
    vx = dx * tps;
    vy = dy * tps;
    if (!m_bias_taken) begin    // first tick after re-zero sets the offsets
      m_bias_vx = clamp32(vx);
      m_bias_vy = clamp32(vy);
      m_bias_taken = 1'b1;
    end
    pose.pos_x = m_x;
    pose.pos_y = m_y;
    pose.heading = m_ang;
    pose.vel_x = 32'(clamp32(vx - m_bias_vx));
    pose.vel_y = 32'(clamp32(vy - m_bias_vy));
    pose.turn_rate = 32'(clamp32(dth * tps));
  endtask

  // input side: accept, predict; output side: compare against oldest
  always @(posedge clk_i) begin
    dod_out_t pred, exp_pose;
    req_taken = in_valid_i && !in_stall_o && rst_ni;
    if (req_taken) begin
      track_pose(in_data_i, pred);
      pose_expected.push_back(pred);
      n_reqs++;
      if (in_data_i.kind) n_rezero++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pose_expected.size() == 0) begin
        $error("pose result with none expected");
        n_errors++;
      end else begin
        exp_pose = pose_expected.pop_front();
        if (out_data_o.pos_x !== exp_pose.pos_x) begin
          $error("pos_x exp %0d got %0d", exp_pose.pos_x, out_data_o.pos_x); n_errors++;
        end
        if (out_data_o.pos_y !== exp_pose.pos_y) begin
          $error("pos_y exp %0d got %0d", exp_pose.pos_y, out_data_o.pos_y); n_errors++;
        end
        if (out_data_o.heading !== exp_pose.heading) begin
          $error("heading exp %0h got %0h", exp_pose.heading, out_data_o.heading);
          n_errors++;
        end
        if (out_data_o.speed_left !== exp_pose.speed_left) begin
          $error("speed_left exp %0d got %0d", exp_pose.speed_left,
                 out_data_o.speed_left); n_errors++;
        end
        if (out_data_o.speed_right !== exp_pose.speed_right) begin
          $error("speed_right exp %0d got %0d", exp_pose.speed_right,
                 out_data_o.speed_right); n_errors++;
        end
        if (out_data_o.vel_x !== exp_pose.vel_x) begin
          $error("vel_x exp %0d got %0d", exp_pose.vel_x, out_data_o.vel_x); n_errors++;
        end
        if (out_data_o.vel_y !== exp_pose.vel_y) begin
          $error("vel_y exp %0d got %0d", exp_pose.vel_y, out_data_o.vel_y); n_errors++;
        end
        if (out_data_o.turn_rate !== exp_pose.turn_rate) begin
          $error("turn_rate exp %0d got %0d", exp_pose.turn_rate,
                 out_data_o.turn_rate); n_errors++;
        end
      end
    end
    // watchdog: only counts while work is outstanding
    if (req_taken || (out_valid_o && !out_stall_i) ||
        (pending_reqs.size() == 0 && pose_expected.size() == 0)) begin
      idle_cnt = 0;
    end else if (++idle_cnt >= IdleLimit) begin
      $display("tb_differential_drive_odometry: done, errors");
      $finish;
    end
  end

  // request driver: holds a request until taken, idles at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (req_taken) void'(pending_reqs.pop_front());
      if (in_valid_i && !req_taken) begin
        // stalled: keep offering the same request
      end else if (pending_reqs.size() > 0 &&
                   !(jitter_on && $urandom_range(99) < 19)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= jitter_on && ($urandom_range(99) < 19);
    end
  end

  task automatic write_reg(input dod_reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= RegAddrW'({idx, 2'b00}); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LEFT_DPT:  m_left_dpt  = val[23:0];
      REG_RIGHT_DPT: m_right_dpt = val[23:0];
      REG_ANGLE_PM:  m_angle_pm  = val;
      REG_TPS:       m_tps       = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [23:0] l, input logic [23:0] r,
                          input logic [31:0] apm, input logic [15:0] tps);
    write_reg(REG_LEFT_DPT, l);
    write_reg(REG_RIGHT_DPT, r);
    write_reg(REG_ANGLE_PM, apm);
    write_reg(REG_TPS, tps);
  endtask

  // sender pause: nothing new until every result is back
  task automatic drain();
    while (pending_reqs.size() != 0 || pose_expected.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_req(input logic kind, input logic [31:0] cl,
                          input logic [31:0] cr);
    dod_in_t r;
    r.kind = kind; r.count_left = cl; r.count_right = cr;
    pending_reqs.push_back(r);
  endtask

  initial begin
    logic [31:0] cl, cr;
    int sel;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    m_left_dpt = '0; m_right_dpt = '0; m_angle_pm = '0; m_tps = 16'd10;
    m_last_l = '0; m_last_r = '0; m_x = '0; m_y = '0; m_ang = '0;
    m_bias_vx = 0; m_bias_vy = 0; m_bias_taken = 1'b0;
    n_errors = 0; n_reqs = 0; n_results = 0; n_rezero = 0;
    jitter_on = 1'b1; hold_reqs = 0; hold_seen = 0; hold_left = 0;
    req_taken = 1'b0; idle_cnt = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // reset defaults: zero travel gains, so pose stays put
    push_req(1'b0, 32'd1000, -32'sd1000);
    drain();

    // directed: extreme gains and counts, wrap of the deltas
    set_regs(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(1'b1, 32'h0, 32'h0);
    push_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);   // opposite max deltas
    push_req(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);   // wrapped back
    push_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // saturated travel
    push_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);   // re-zero at extremes
    push_req(1'b0, 32'h8000_0001, 32'h7FFF_FFFE);
    drain();
    // zero sample rate: all rates vanish
    set_regs(24'd429497, 24'd429497, 32'd500000, 16'd0);
    push_req(1'b1, 32'd0, 32'd0);
    for (int i = 1; i <= 4; i++) push_req(1'b0, 32'(i * 300), 32'(i * 200));
    drain();
    // slowest rate, spinning in place over several quadrants
    set_regs(24'd429497, 24'd429497, 32'hFFFF_FFFF, 16'd1);
    push_req(1'b1, 32'd0, 32'd0);
    for (int i = 1; i <= 6; i++) push_req(1'b0, -32'(i * 90000), 32'(i * 90000));
    push_req(1'b0, 32'd0, 32'd0);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(24'hFF_FFFF, 24'h0, 32'hFFFF_FFFF, 16'hFFFF);
        1: set_regs(24'h0, 24'hFF_FFFF, 32'h0, 16'd1);
        default: set_regs(24'($urandom), 24'($urandom), $urandom,
                          16'($urandom_range(1, 65535)));
      endcase
      jitter_on = (ph != 3);          // one phase with no idling at all
      if (ph == 2) hold_reqs++;       // receiver sits on results a while
      cl = $urandom; cr = $urandom;
      push_req(1'b1, cl, cr);
      for (int k = 0; k < 250; k++) begin
        sel = $urandom_range(99);
        if (sel < 5) begin
          cl = $urandom; cr = $urandom;
          push_req(1'b1, cl, cr);
        end else if (sel < 15) begin
          cl = $urandom; cr = $urandom;
          push_req(1'b0, cl, cr);
        end else begin
          cl += 32'($urandom_range(0, 8000)) - 32'd4000;
          cr += 32'($urandom_range(0, 8000)) - 32'd4000;
          push_req(1'b0, cl, cr);
        end
      end
      drain();
    end

    repeat (Settle) @(posedge clk_i);
    if (pose_expected.size() != 0) begin
      $error("%0d pose results never arrived", pose_expected.size());
      n_errors++;
    end
    $display("covered %0d requests (%0d re-zero), %0d results checked, 11 settings",
             n_reqs, n_rezero, n_results);
    if (n_errors == 0) begin
      $display("tb_differential_drive_odometry: done, clean");
    end else begin
      $display("tb_differential_drive_odometry: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- differential_drive_odometry.f -----
+incdir+rtl/core
rtl/core/dod_pkg.sv
rtl/core/dod_mul.sv
rtl/core/dod_cordic.sv
rtl/core/dod_cfg.sv
rtl/core/differential_drive_odometry.sv
tb/tb_differential_drive_odometry.sv
